// ----- design/line_rasterizer_3d_unit_assert.svh -----
// Assertion macros for the rasterizer datapath.
// Each macro expects clk and rst to be visible where it is used.
`ifndef LINE_RASTERIZER_3D_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_3D_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LR3D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LR3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lr3d_pkg.sv -----
package lr3d_pkg;

  localparam int LEVEL_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } lr3d_state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } lr3d_axis_t;

  typedef struct packed {
    logic capture;
    logic setup;
    logic emit;
  } lr3d_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } lr3d_stat_t;

endpackage

// ----- design/lr3d_ctrl.sv -----
module lr3d_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  lr3d_pkg::lr3d_stat_t stat,
  output lr3d_pkg::lr3d_cmd_t  cmd
);
  import lr3d_pkg::*;

  lr3d_state_t state;
  lr3d_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.setup   = 1'b0;
    cmd.emit    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lr3d_datapath.sv -----
`include "line_rasterizer_3d_unit_assert.svh"

module lr3d_datapath #(
  parameter int COORD_BITS = 4,
  parameter int IN_W       = 40,
  parameter int OUT_W      = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lr3d_pkg::lr3d_cmd_t  cmd,
  output lr3d_pkg::lr3d_stat_t stat,
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tlast
);
  import lr3d_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int ERR_W = COORD_BITS + 3;

  logic [CB-1:0]      cap_start [3];
  logic [CB-1:0]      cap_end   [3];
  logic [LEVEL_W-1:0] cap_level;

  logic [CB-1:0] dlt [3];
  logic [2:0]    dir_up;
  lr3d_axis_t    drv_sel;
  logic [CB-1:0] dd_sel;
  logic [CB-1:0] dma_sel;
  logic [CB-1:0] dmb_sel;

  logic [CB-1:0]           pos [3];
  logic [CB-1:0]           pos_next [3];
  logic [2:0]              sgn;
  lr3d_axis_t              drv;
  logic [CB:0]             dd2;
  logic [CB:0]             dma2;
  logic [CB:0]             dmb2;
  logic signed [ERR_W-1:0] ea;
  logic signed [ERR_W-1:0] eb;
  logic signed [ERR_W-1:0] ea_next;
  logic signed [ERR_W-1:0] eb_next;
  logic [CB-1:0]           rem;
  logic [LEVEL_W-1:0]      level;
  logic                    a_step;
  logic                    b_step;
  logic [2:0]              step_en;

  logic [CB-1:0]      out_x;
  logic [CB-1:0]      out_y;
  logic [CB-1:0]      out_z;
  logic [LEVEL_W-1:0] out_level;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        cap_start[i] <= s_tdata[i*CB +: CB];
        cap_end[i]   <= s_tdata[(i+3)*CB +: CB];
      end
      cap_level <= s_tdata[6*CB +: LEVEL_W];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_up[i] = cap_end[i] > cap_start[i];
      dlt[i]    = dir_up[i] ? (cap_end[i] - cap_start[i]) : (cap_start[i] - cap_end[i]);
    end
    if (dlt[0] >= dlt[1] && dlt[0] >= dlt[2]) begin
      drv_sel = AXIS_X;
      dd_sel  = dlt[0];
      dma_sel = dlt[1];
      dmb_sel = dlt[2];
    end else if (dlt[1] >= dlt[2]) begin
      drv_sel = AXIS_Y;
      dd_sel  = dlt[1];
      dma_sel = dlt[0];
      dmb_sel = dlt[2];
    end else begin
      drv_sel = AXIS_Z;
      dd_sel  = dlt[2];
      dma_sel = dlt[1];
      dmb_sel = dlt[0];
    end
  end

  assign a_step = !ea[ERR_W-1];
  assign b_step = !eb[ERR_W-1];

  always_comb begin
    case (drv)
      AXIS_X:  step_en = {b_step, a_step, 1'b1};
      AXIS_Y:  step_en = {b_step, 1'b1, a_step};
      AXIS_Z:  step_en = {1'b1, a_step, b_step};
      default: step_en = 3'b000;
    endcase
    for (int i = 0; i < 3; i++) begin
      if (step_en[i]) begin
        pos_next[i] = sgn[i] ? (pos[i] + CB'(1)) : (pos[i] - CB'(1));
      end else begin
        pos_next[i] = pos[i];
      end
    end
    ea_next = ea - (a_step ? $signed({{(ERR_W-CB-1){1'b0}}, dd2}) : ERR_W'(0))
                 + $signed({{(ERR_W-CB-1){1'b0}}, dma2});
    eb_next = eb - (b_step ? $signed({{(ERR_W-CB-1){1'b0}}, dd2}) : ERR_W'(0))
                 + $signed({{(ERR_W-CB-1){1'b0}}, dmb2});
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= cap_start[i];
      end
      sgn   <= dir_up;
      drv   <= drv_sel;
      dd2   <= {dd_sel, 1'b0};
      dma2  <= {dma_sel, 1'b0};
      dmb2  <= {dmb_sel, 1'b0};
      ea    <= $signed({{(ERR_W-CB-1){1'b0}}, dma_sel, 1'b0})
               - $signed({{(ERR_W-CB){1'b0}}, dd_sel});
      eb    <= $signed({{(ERR_W-CB-1){1'b0}}, dmb_sel, 1'b0})
               - $signed({{(ERR_W-CB){1'b0}}, dd_sel});
      rem   <= dd_sel;
      level <= cap_level;
    end else if (cmd.emit && rem != '0) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= pos_next[i];
      end
      ea  <= ea_next;
      eb  <= eb_next;
      rem <= rem - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x     <= pos[0];
      out_y     <= pos[1];
      out_z     <= pos[2];
      out_level <= level;
      m_tlast   <= (rem == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata       = OUT_W'({out_level, out_z, out_y, out_x});
  assign stat.last     = (rem == '0);
  assign stat.out_free = !m_tvalid || m_tready;

  `LR3D_ASSERT_NOW(a_emit_room, cmd.emit, (!m_tvalid || m_tready), "voxel loaded over a held beat")
  `LR3D_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid, "loaded voxel not presented")
  `LR3D_ASSERT_NEXT(a_rem_count, (cmd.emit && rem != '0), (rem == $past(rem) - CB'(1)), "voxel count did not step")
  `LR3D_ASSERT_NEXT(a_last_flag, (cmd.emit && rem == '0), m_tlast, "final voxel lacks tlast")

endmodule

// ----- design/line_rasterizer_3d_unit.sv -----
// The request beat is captured, the setup state loads the stepper, then the first voxel is loaded and presented.
// Throughput: a line of N voxels (longest axis delta plus one) is emitted
// one voxel per cycle from a single stepping unit, with no output stalls.
// A new request is taken once the final voxel is loaded, even while it waits.
// Reset (rst, synchronous, active high) returns the controller to idle and drops m_tvalid.
module line_rasterizer_3d_unit #(
  parameter int COORD_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, brightness, zero fill
  input  logic [((6*COORD_BITS+16+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // voxel_x, voxel_y, voxel_z, voxel_level, zero fill
  output logic [((3*COORD_BITS+16+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);
  import lr3d_pkg::*;

  localparam int IN_W  = ((6*COORD_BITS+LEVEL_W+7)/8)*8;
  localparam int OUT_W = ((3*COORD_BITS+LEVEL_W+7)/8)*8;

  lr3d_cmd_t  cmd;
  lr3d_stat_t stat;

  lr3d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lr3d_datapath #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sim/line_rasterizer_3d_checker.sv -----
module line_rasterizer_3d_checker #(
  parameter int COORD_BITS = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, brightness, zero fill
  input  logic [((6*COORD_BITS+16+7)/8)*8-1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  // voxel_x, voxel_y, voxel_z, voxel_level, zero fill
  input  logic [((3*COORD_BITS+16+7)/8)*8-1:0] m_tdata,
  input  logic m_tlast,
  output int   mismatches,
  output int   voxels_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lr3d_pkg::*;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [LEVEL_W-1:0]    level;
    logic                  last;
  } voxel_t;

  voxel_t voxels_due[$];

  // Walker state after the most recent line.
  logic [COORD_BITS-1:0] walk_x, walk_y, walk_z;
  logic signed [6:0]     walk_err_a, walk_err_b;
  lr3d_axis_t            walk_axis;

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic rasterize_line(input logic [((6*COORD_BITS+16+7)/8)*8-1:0] beat);
    int pos[3], tgt[3], span[3], dir[3];
    int drv, ma, mb, acc_a, acc_b, steps;
    voxel_t v;
    for (int i = 0; i < 3; i++) begin
      pos[i]  = int'(beat[i*COORD_BITS +: COORD_BITS]);
      tgt[i]  = int'(beat[(i+3)*COORD_BITS +: COORD_BITS]);
      span[i] = (tgt[i] > pos[i]) ? tgt[i] - pos[i] : pos[i] - tgt[i];
      dir[i]  = (tgt[i] > pos[i]) ? 1 : -1;
    end
    // The longest axis drives; ties go to x, then y.
    if (span[0] >= span[1] && span[0] >= span[2]) begin
      walk_axis = AXIS_X;
    end else if (span[1] >= span[2]) begin
      walk_axis = AXIS_Y;
    end else begin
      walk_axis = AXIS_Z;
    end
    case (walk_axis)
      AXIS_X: begin
        drv = 0; ma = 1; mb = 2;
      end
      AXIS_Y: begin
        drv = 1; ma = 0; mb = 2;
      end
      default: begin
        drv = 2; ma = 1; mb = 0;
      end
    endcase
    steps = span[drv];
    acc_a = (steps == 0) ? 0 : 2 * span[ma] - steps;
    acc_b = (steps == 0) ? 0 : 2 * span[mb] - steps;
    for (int k = 0; k <= steps; k++) begin
      if (k > 0) begin
        pos[drv] += dir[drv];
        if (acc_a >= 0) begin
          pos[ma] += dir[ma];
          acc_a   -= 2 * steps;
        end
        if (acc_b >= 0) begin
          pos[mb] += dir[mb];
          acc_b   -= 2 * steps;
        end
        acc_a += 2 * span[ma];
        acc_b += 2 * span[mb];
      end
      v.x     = pos[0][COORD_BITS-1:0];
      v.y     = pos[1][COORD_BITS-1:0];
      v.z     = pos[2][COORD_BITS-1:0];
      v.level = beat[6*COORD_BITS +: LEVEL_W];
      v.last  = (k == steps);
      voxels_due.push_back(v);
    end
    walk_x     = pos[0][COORD_BITS-1:0];
    walk_y     = pos[1][COORD_BITS-1:0];
    walk_z     = pos[2][COORD_BITS-1:0];
    walk_err_a = acc_a[6:0];
    walk_err_b = acc_b[6:0];
  endtask

  always @(posedge clk) begin
    voxel_t want;
    if (rst) begin
      voxels_due.delete();
      walk_x     = '0;
      walk_y     = '0;
      walk_z     = '0;
      walk_err_a = '0;
      walk_err_b = '0;
      walk_axis  = AXIS_X;
    end else begin
      if (m_tvalid && m_tready) begin
        if (voxels_due.size() == 0) begin
          $error("voxel beat with nothing expected: x=%0d y=%0d z=%0d",
                 m_tdata[0 +: COORD_BITS], m_tdata[COORD_BITS +: COORD_BITS],
                 m_tdata[2*COORD_BITS +: COORD_BITS]);
          mismatches++;
        end else begin
          want = voxels_due.pop_front();
          check_field("voxel_x", want.x, m_tdata[0 +: COORD_BITS]);
          check_field("voxel_y", want.y, m_tdata[COORD_BITS +: COORD_BITS]);
          check_field("voxel_z", want.z, m_tdata[2*COORD_BITS +: COORD_BITS]);
          check_field("voxel_level", want.level, m_tdata[3*COORD_BITS +: LEVEL_W]);
          check_field("last_voxel", want.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) begin
        rasterize_line(s_tdata);
      end
    end
    voxels_pending <= voxels_due.size();
  end

endmodule

// ----- sim/line_rasterizer_3d_unit_tb.sv -----
module line_rasterizer_3d_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS  = 4;
  localparam int IN_W        = ((6*COORD_BITS+16+7)/8)*8;
  localparam int OUT_W       = ((3*COORD_BITS+16+7)/8)*8;
  localparam int RANDOM_LINES = 230;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  int mismatches;
  int voxels_pending;
  int lines_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  line_rasterizer_3d_unit #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  line_rasterizer_3d_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .voxels_pending (voxels_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one line, waits for the falling edge after its beat is taken, and may then idle for a random gap.
  task automatic send_line(input logic [3:0] sx, sy, sz, ex, ey, ez,
                           input logic [15:0] level);
    int gap;
    s_tdata  <= {level, ez, ey, ex, sz, sy, sx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    lines_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= IN_W'({$urandom, $urandom});
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
    end
  endtask

  initial begin
    logic [3:0] sx, sy, sz, ex, ey, ez;
    int pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Equal endpoints at both corners of the cube and inside it.
    send_line(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0000);
    send_line(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 16'hFFFF);
    send_line(4'd7, 4'd9, 4'd3, 4'd7, 4'd9, 4'd3, 16'h8001);
    // Full-length lines along each axis, both directions.
    send_line(4'd0, 4'd5, 4'd9, 4'd15, 4'd5, 4'd9, 16'h5555);
    send_line(4'd15, 4'd5, 4'd9, 4'd0, 4'd5, 4'd9, 16'hAAAA);
    send_line(4'd3, 4'd0, 4'd12, 4'd3, 4'd15, 4'd12, 16'h1234);
    send_line(4'd3, 4'd15, 4'd12, 4'd3, 4'd0, 4'd12, 16'hFEDC);
    send_line(4'd8, 4'd1, 4'd0, 4'd8, 4'd1, 4'd15, 16'h00FF);
    send_line(4'd8, 4'd1, 4'd15, 4'd8, 4'd1, 4'd0, 16'hFF00);
    // Main diagonals, where all three deltas tie.
    send_line(4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 4'd15, 16'h0F0F);
    send_line(4'd15, 4'd0, 4'd15, 4'd0, 4'd15, 4'd0, 16'hF0F0);
    // Two-way ties: x with y, y with z, x with z.
    send_line(4'd2, 4'd2, 4'd7, 4'd9, 4'd9, 4'd8, 16'h0001);
    send_line(4'd1, 4'd12, 4'd12, 4'd3, 4'd4, 4'd4, 16'h8000);
    send_line(4'd14, 4'd6, 4'd0, 4'd4, 4'd7, 4'd10, 16'h7FFF);
    // Shallow minor slopes in mixed directions.
    send_line(4'd0, 4'd15, 4'd3, 4'd15, 4'd12, 4'd0, 16'h3C3C);
    send_line(4'd13, 4'd2, 4'd15, 4'd11, 4'd3, 4'd0, 16'hC3C3);
    send_line(4'd5, 4'd14, 4'd6, 4'd6, 4'd0, 4'd5, 16'h9669);
    // Single-step lines.
    send_line(4'd4, 4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 16'h6996);
    send_line(4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd9, 16'hFFFE);

    repeat (RANDOM_LINES) begin
      pick = $urandom_range(0, 9);
      sx = 4'($urandom_range(0, 15));
      sy = 4'($urandom_range(0, 15));
      sz = 4'($urandom_range(0, 15));
      ex = 4'($urandom_range(0, 15));
      ey = 4'($urandom_range(0, 15));
      ez = 4'($urandom_range(0, 15));
      if (pick < 3) begin
        // Short lines keep the pipeline turning over quickly.
        ex = sx ^ 4'($urandom_range(0, 3));
        ey = sy ^ 4'($urandom_range(0, 3));
        ez = sz ^ 4'($urandom_range(0, 3));
      end else if (pick == 3) begin
        ez = sz;
      end else if (pick == 4) begin
        sy = sx;
        ey = ex;
      end else if (pick == 5) begin
        sz = sy;
        ez = ey;
      end
      send_line(sx, sy, sz, ex, ey, ez, 16'($urandom_range(0, 65535)));
    end

    s_tvalid <= 1'b0;
    while (voxels_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output side: a new stall pattern is picked whenever the current phase runs out, with two long
  // hold-offs that let the block back up into its input.
  initial begin
    int mode, phase_left, hold_left, holds_done, tick;
    m_tready   = 1'b0;
    mode       = 0;
    phase_left = 0;
    hold_left  = 0;
    holds_done = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left == 0 && holds_done < 2 && lines_sent >= 60 * (holds_done + 1)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
+incdir+design
design/lr3d_pkg.sv
design/lr3d_ctrl.sv
design/lr3d_datapath.sv
design/line_rasterizer_3d_unit.sv
sim/line_rasterizer_3d_checker.sv
sim/line_rasterizer_3d_unit_tb.sv
